// File: design/tsc_pkg.sv
// Package with shared types, constants and helpers for the turn sequence checker.
package tsc_pkg;

    localparam int EVENT_DEPTH = 64;
    localparam int IDX_W = $clog2(EVENT_DEPTH);
    localparam int CNT_W = $clog2(EVENT_DEPTH + 1);

    localparam logic [31:0] U32_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [1:0] LS_OFFLINE = 2'd0;
    localparam logic [1:0] LS_ONLINE  = 2'd1;
    localparam logic [1:0] LS_FAILED  = 2'd2;

    localparam logic [1:0] PH_RETIRED   = 2'd0;
    localparam logic [1:0] PH_UPLOADING = 2'd1;
    localparam logic [1:0] PH_WAITING   = 2'd2;
    localparam logic [1:0] PH_COMPLETE  = 2'd3;

    localparam logic [2:0] KIND_ONLINE  = 3'd0;
    localparam logic [2:0] KIND_AUDIO   = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;
    localparam logic [2:0] KIND_OFFLINE = 3'd5;

    localparam logic [3:0] MD_START    = 4'd0;
    localparam logic [3:0] MD_CANCEL   = 4'd1;
    localparam logic [3:0] MD_UPLINK   = 4'd2;
    localparam logic [3:0] MD_END      = 4'd3;
    localparam logic [3:0] MD_READY    = 4'd4;
    localparam logic [3:0] MD_AUDIO    = 4'd5;
    localparam logic [3:0] MD_DONE     = 4'd6;
    localparam logic [3:0] MD_ERROR    = 4'd7;
    localparam logic [3:0] MD_OTHER    = 4'd8;
    localparam logic [3:0] MD_INVALID  = 4'd9;
    localparam logic [3:0] MD_POP      = 4'd10;
    localparam logic [3:0] MD_RESTART  = 4'd11;
    localparam logic [3:0] MD_LEVEL    = 4'd12;
    localparam logic [3:0] MD_LINKFAIL = 4'd13;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BACKP   = 3'd1;
    localparam logic [2:0] ST_DISC    = 3'd2;
    localparam logic [2:0] ST_STALE   = 3'd3;
    localparam logic [2:0] ST_QUEUED  = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_POPPED  = 3'd6;

    localparam logic [3:0] FR_NONE       = 4'd0;
    localparam logic [3:0] FR_PROTOCOL   = 4'd1;
    localparam logic [3:0] FR_DUP_READY  = 4'd2;
    localparam logic [3:0] FR_EARLY_MSG  = 4'd3;
    localparam logic [3:0] FR_ORDER      = 4'd4;
    localparam logic [3:0] FR_OVERFLOW   = 4'd5;
    localparam logic [3:0] FR_CTRL_BACKP = 4'd6;
    localparam logic [3:0] FR_EXHAUSTED  = 4'd7;
    localparam logic [3:0] FR_UPLINK     = 4'd8;
    localparam logic [3:0] FR_END        = 4'd9;
    localparam logic [3:0] FR_LINK       = 4'd10;

    localparam logic CFG_SEND_LIMIT = 1'b0;
    localparam logic CFG_FULL_FRAME = 1'b1;

    // Queue entry: kind in bits 2..0, in-turn flag in bit 3.
    typedef logic [3:0] t_entry;

    typedef struct packed {
        logic             shift;
        logic             we;
        logic [IDX_W-1:0] widx;
        t_entry           wdata;
    } t_chain_ctl;

    // Number of decimal digits of a 32-bit value.
    function automatic logic [3:0] decimal_digits(input logic [31:0] v);
        logic [3:0] n;
        n = 4'd1;
        if (v >= 32'd10) n = 4'd2;
        if (v >= 32'd100) n = 4'd3;
        if (v >= 32'd1000) n = 4'd4;
        if (v >= 32'd10000) n = 4'd5;
        if (v >= 32'd100000) n = 4'd6;
        if (v >= 32'd1000000) n = 4'd7;
        if (v >= 32'd10000000) n = 4'd8;
        if (v >= 32'd100000000) n = 4'd9;
        if (v >= 32'd1000000000) n = 4'd10;
        return n;
    endfunction

endpackage

// File: design/tsc_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface tsc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic        retract;
    logic [31:0] msg_turn;
    logic [31:0] msg_sequence;
    logic [13:0] payload_bytes;
    logic [15:0] buffer_level;

    modport source (output valid, mode, retract, msg_turn, msg_sequence, payload_bytes,
                    buffer_level, input ready);
    modport sink (input valid, mode, retract, msg_turn, msg_sequence, payload_bytes,
                  buffer_level, output ready);
endinterface

interface tsc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  fail_reason;
    logic [31:0] turn_number;
    logic [31:0] frame_sequence;
    logic [2:0]  popped_kind;
    logic        popped_in_turn;
    logic [1:0]  link_state;
    logic [1:0]  turn_phase;
    logic [6:0]  queue_count;

    modport source (output valid, status, fail_reason, turn_number, frame_sequence,
                    popped_kind, popped_in_turn, link_state, turn_phase, queue_count,
                    input ready);
    modport sink (input valid, status, fail_reason, turn_number, frame_sequence,
                  popped_kind, popped_in_turn, link_state, turn_phase, queue_count,
                  output ready);
endinterface

// File: design/turn_sequence_checker_core.sv
// Top level of the turn sequence checker: turn state, send accounting and event queue.
// The result is registered; when a successful start or cancel, or a restart, finds events
// queued, it waits until compaction has walked every queued event through the cell row.
// One item at a time: a new item is taken only after the last result has been taken.
// Reset (synchronous, active low): link offline, turn retired, counters and queue empty,
// registers at their defaults; queue cells are not cleared.
module turn_sequence_checker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    tsc_in_if.sink        i_in,
    tsc_out_if.source     o_out
);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COMPACT = 1'b1;

    localparam int CW = tsc_pkg::CNT_W;
    localparam int IW = tsc_pkg::IDX_W;

    logic        r_state;
    logic [15:0] r_limit;
    logic [13:0] r_full;
    logic [1:0]  r_link;
    logic [1:0]  r_phase;
    logic [31:0] r_turn;
    logic [31:0] r_up;
    logic [31:0] r_down;
    logic        r_ended;
    logic [15:0] r_buf;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_len;

    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [3:0]  r_reason;
    logic [31:0] r_oturn;
    logic [31:0] r_fseq;
    logic [2:0]  r_pk;
    logic        r_pin;
    logic [1:0]  r_olink;
    logic [1:0]  r_ophase;
    logic [CW-1:0] r_ocnt;

    logic [1:0]  n_link;
    logic [1:0]  n_phase;
    logic [31:0] n_turn;
    logic [31:0] n_up;
    logic [31:0] n_down;
    logic        n_ended;
    logic [15:0] n_buf;
    logic [CW-1:0] n_cnt;
    logic [2:0]  n_status;
    logic [3:0]  n_reason;
    logic [31:0] n_fseq;
    logic [2:0]  n_pk;
    logic        n_pin;
    logic        n_compact;

    logic        w_accept;
    logic        w_fail;
    logic [3:0]  w_fail_code;
    logic        w_push;
    logic [2:0]  w_kind;
    logic [31:0] w_next;
    logic [13:0] w_size;
    logic [16:0] w_sum;
    logic        w_over;
    logic        w_audio;
    logic        w_keep;
    logic [CW-1:0] w_len_dec;
    logic [CW-1:0] w_len_new;

    tsc_pkg::t_chain_ctl w_ctl;
    tsc_pkg::t_entry     w_head;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && !r_ovalid;

    assign w_next  = r_turn + 32'd1;
    assign w_kind  = 3'(i_in.mode - tsc_pkg::MD_READY);
    assign w_audio = (w_kind == tsc_pkg::KIND_AUDIO);

    // Bytes that this item would add to the transmit buffer.
    always_comb begin
        case (i_in.mode)
            tsc_pkg::MD_START:  w_size = 14'(tsc_pkg::decimal_digits(w_next)) + 14'd8;
            tsc_pkg::MD_CANCEL: w_size = 14'(tsc_pkg::decimal_digits(w_next)) + 14'd9;
            tsc_pkg::MD_UPLINK: w_size = i_in.payload_bytes;
            tsc_pkg::MD_END:    w_size = 14'(tsc_pkg::decimal_digits(r_turn)) + 14'd4;
            default:            w_size = '0;
        endcase
    end

    assign w_sum  = {1'b0, r_buf} + {3'b000, w_size};
    assign w_over = w_sum > {1'b0, r_limit};

    always_comb begin
        n_link      = r_link;
        n_phase     = r_phase;
        n_turn      = r_turn;
        n_up        = r_up;
        n_down      = r_down;
        n_ended     = r_ended;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_status    = tsc_pkg::ST_OK;
        n_reason    = tsc_pkg::FR_NONE;
        n_fseq      = '0;
        n_pk        = '0;
        n_pin       = 1'b0;
        n_compact   = 1'b0;
        w_fail      = 1'b0;
        w_fail_code = tsc_pkg::FR_NONE;
        w_push      = 1'b0;
        w_ctl       = '0;

        case (i_in.mode)
            tsc_pkg::MD_START, tsc_pkg::MD_CANCEL: begin
                n_status = tsc_pkg::ST_DISC;
                if (r_turn == tsc_pkg::U32_ALL_ONES) begin
                    w_fail      = 1'b1;
                    w_fail_code = tsc_pkg::FR_EXHAUSTED;
                end else if (r_link == tsc_pkg::LS_ONLINE) begin
                    if (w_over) begin
                        w_fail      = 1'b1;
                        w_fail_code = tsc_pkg::FR_CTRL_BACKP;
                    end else begin
                        n_status  = tsc_pkg::ST_OK;
                        n_buf     = w_sum[15:0];
                        n_turn    = w_next;
                        n_phase   = (i_in.mode == tsc_pkg::MD_START) ?
                                    tsc_pkg::PH_UPLOADING : tsc_pkg::PH_RETIRED;
                        n_up      = '0;
                        n_down    = '0;
                        n_ended   = 1'b0;
                        n_compact = 1'b1;
                    end
                end
            end
            tsc_pkg::MD_UPLINK: begin
                n_status = tsc_pkg::ST_DISC;
                if (r_link == tsc_pkg::LS_ONLINE) begin
                    if (r_phase != tsc_pkg::PH_UPLOADING || r_up == tsc_pkg::U32_ALL_ONES) begin
                        w_fail      = 1'b1;
                        w_fail_code = tsc_pkg::FR_UPLINK;
                    end else if (w_over) begin
                        n_status = tsc_pkg::ST_BACKP;
                    end else begin
                        n_status = tsc_pkg::ST_OK;
                        n_buf    = w_sum[15:0];
                        n_fseq   = r_up;
                        n_up     = r_up + 32'd1;
                    end
                end
            end
            tsc_pkg::MD_END: begin
                n_status = tsc_pkg::ST_DISC;
                if (r_link == tsc_pkg::LS_ONLINE) begin
                    if (r_phase != tsc_pkg::PH_UPLOADING || r_up == 32'd0) begin
                        w_fail      = 1'b1;
                        w_fail_code = tsc_pkg::FR_END;
                    end else if (w_over) begin
                        n_status = tsc_pkg::ST_BACKP;
                    end else begin
                        n_status = tsc_pkg::ST_OK;
                        n_buf    = w_sum[15:0];
                        n_phase  = tsc_pkg::PH_WAITING;
                    end
                end
            end
            tsc_pkg::MD_READY, tsc_pkg::MD_AUDIO, tsc_pkg::MD_DONE,
            tsc_pkg::MD_ERROR, tsc_pkg::MD_OTHER: begin
                n_status = tsc_pkg::ST_DISC;
                if (r_link == tsc_pkg::LS_FAILED) begin
                    n_status = tsc_pkg::ST_DISC;
                end else if (w_kind == tsc_pkg::KIND_ONLINE) begin
                    if (r_link == tsc_pkg::LS_ONLINE) begin
                        w_fail      = 1'b1;
                        w_fail_code = tsc_pkg::FR_DUP_READY;
                    end else begin
                        n_link = tsc_pkg::LS_ONLINE;
                        w_push = 1'b1;
                    end
                end else if (r_link != tsc_pkg::LS_ONLINE) begin
                    w_fail      = 1'b1;
                    w_fail_code = tsc_pkg::FR_EARLY_MSG;
                end else if (i_in.msg_turn < r_turn ||
                             (i_in.msg_turn == r_turn && r_phase == tsc_pkg::PH_RETIRED)) begin
                    n_status = tsc_pkg::ST_STALE;
                end else if (r_turn == 32'd0 || i_in.msg_turn != r_turn ||
                             r_phase == tsc_pkg::PH_COMPLETE ||
                             (r_phase == tsc_pkg::PH_UPLOADING &&
                              w_kind != tsc_pkg::KIND_ERROR) ||
                             (w_audio && (r_ended || i_in.msg_sequence != r_down))) begin
                    w_fail      = 1'b1;
                    w_fail_code = tsc_pkg::FR_ORDER;
                end else begin
                    w_push = 1'b1;
                    if (w_audio) begin
                        n_down  = r_down + 32'd1;
                        n_ended = i_in.payload_bytes < r_full;
                    end else if (w_kind == tsc_pkg::KIND_DONE ||
                                 w_kind == tsc_pkg::KIND_ERROR) begin
                        n_phase = tsc_pkg::PH_COMPLETE;
                    end
                end
                if (w_push) begin
                    if (r_cnt >= CW'(tsc_pkg::EVENT_DEPTH)) begin
                        w_push      = 1'b0;
                        w_fail      = 1'b1;
                        w_fail_code = tsc_pkg::FR_OVERFLOW;
                    end else begin
                        n_status    = tsc_pkg::ST_QUEUED;
                        n_cnt       = r_cnt + CW'(1);
                        w_ctl.we    = 1'b1;
                        w_ctl.widx  = r_cnt[IW-1:0];
                        // Ready events carry no turn.
                        w_ctl.wdata = {(w_kind != tsc_pkg::KIND_ONLINE) &&
                                       (i_in.msg_turn != 32'd0), w_kind};
                    end
                end
            end
            tsc_pkg::MD_INVALID: begin
                n_status    = tsc_pkg::ST_DISC;
                w_fail      = 1'b1;
                w_fail_code = tsc_pkg::FR_PROTOCOL;
            end
            tsc_pkg::MD_POP: begin
                if (r_cnt == '0) begin
                    n_status = tsc_pkg::ST_EMPTY;
                end else begin
                    n_status    = tsc_pkg::ST_POPPED;
                    n_pk        = w_head[2:0];
                    n_pin       = w_head[3];
                    n_cnt       = r_cnt - CW'(1);
                    w_ctl.shift = 1'b1;
                end
            end
            tsc_pkg::MD_RESTART: begin
                n_link    = tsc_pkg::LS_OFFLINE;
                n_phase   = tsc_pkg::PH_RETIRED;
                n_up      = '0;
                n_down    = '0;
                n_ended   = 1'b0;
                n_buf     = '0;
                n_compact = 1'b1;
            end
            tsc_pkg::MD_LEVEL: begin
                n_buf = i_in.buffer_level;
            end
            tsc_pkg::MD_LINKFAIL: begin
                n_status    = tsc_pkg::ST_DISC;
                w_fail      = 1'b1;
                w_fail_code = tsc_pkg::FR_LINK;
            end
            default: begin
            end
        endcase

        // The first failure wins: queue emptied and a single offline event queued.
        if (w_fail && r_link != tsc_pkg::LS_FAILED) begin
            n_link      = tsc_pkg::LS_FAILED;
            n_phase     = tsc_pkg::PH_RETIRED;
            n_reason    = w_fail_code;
            n_cnt       = CW'(1);
            w_ctl.shift = 1'b0;
            w_ctl.we    = 1'b1;
            w_ctl.widx  = '0;
            w_ctl.wdata = {1'b0, tsc_pkg::KIND_OFFLINE};
        end

        if (!w_accept) begin
            w_ctl = '0;
        end

        // Compaction: the head leaves each cycle and a kept entry is appended at the tail.
        if (r_state == ST_COMPACT) begin
            w_ctl.shift = 1'b1;
            w_ctl.we    = w_keep;
            w_ctl.widx  = w_len_dec[IW-1:0];
            w_ctl.wdata = w_head;
        end
    end

    assign w_keep    = !w_head[3];
    assign w_len_dec = r_len - CW'(1);
    assign w_len_new = w_keep ? r_len : w_len_dec;

    tsc_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_limit  <= 16'd20480;
            r_full   <= 14'd640;
            r_link   <= tsc_pkg::LS_OFFLINE;
            r_phase  <= tsc_pkg::PH_RETIRED;
            r_turn   <= '0;
            r_up     <= '0;
            r_down   <= '0;
            r_ended  <= 1'b0;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tsc_pkg::CFG_SEND_LIMIT) begin
                    r_limit <= i_cfg_data;
                end else begin
                    r_full <= i_cfg_data[13:0];
                end
            end
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                r_link  <= n_link;
                r_phase <= n_phase;
                r_turn  <= n_turn;
                r_up    <= n_up;
                r_down  <= n_down;
                r_ended <= n_ended;
                r_buf   <= n_buf;
                r_cnt   <= n_cnt;
                if (n_compact && r_cnt != '0) begin
                    r_state <= ST_COMPACT;
                    r_rem   <= r_cnt;
                    r_len   <= r_cnt;
                end else begin
                    r_ovalid <= 1'b1;
                end
            end
            if (r_state == ST_COMPACT) begin
                r_rem <= r_rem - CW'(1);
                r_len <= w_len_new;
                if (r_rem == CW'(1)) begin
                    r_state  <= ST_IDLE;
                    r_cnt    <= w_len_new;
                    r_ovalid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_reason <= n_reason;
            r_oturn  <= n_turn;
            r_fseq   <= n_fseq;
            r_pk     <= n_pk;
            r_pin    <= n_pin;
            r_olink  <= n_link;
            r_ophase <= n_phase;
            r_ocnt   <= n_cnt;
        end
        if (r_state == ST_COMPACT && r_rem == CW'(1)) begin
            r_ocnt <= w_len_new;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_status;
    assign o_out.fail_reason    = r_reason;
    assign o_out.turn_number    = r_oturn;
    assign o_out.frame_sequence = r_fseq;
    assign o_out.popped_kind    = r_pk;
    assign o_out.popped_in_turn = r_pin;
    assign o_out.link_state     = r_olink;
    assign o_out.turn_phase     = r_ophase;
    assign o_out.queue_count    = r_ocnt;

    a_no_result_while_compacting: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPACT) |-> !r_ovalid)
        else $error("result shown during compaction");

    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(tsc_pkg::EVENT_DEPTH))
        else $error("queue count beyond depth");

    a_one_item_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("second item taken before result");

    a_fail_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_reason != tsc_pkg::FR_NONE) |->
        (r_olink == tsc_pkg::LS_FAILED && r_ocnt == CW'(1)))
        else $error("failure without failed link and single offline event");

endmodule

// File: design/tsc_cell.sv
// One queue cell: holds an entry, loads new data or takes its right neighbor's entry.
module tsc_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_we,
    input  tsc_pkg::t_entry i_wdata,
    input  tsc_pkg::t_entry i_nb,
    output tsc_pkg::t_entry o_q
);

    tsc_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_q <= i_wdata;
        end else if (i_shift) begin
            r_q <= i_nb;
        end
    end

    assign o_q = r_q;

endmodule

// File: design/tsc_chain.sv
// Row of queue cells; entries move one cell toward the head on a shift.
module tsc_chain (
    input  logic                i_clk,
    input  tsc_pkg::t_chain_ctl i_ctl,
    output tsc_pkg::t_entry     o_head
);

    tsc_pkg::t_entry w_q [tsc_pkg::EVENT_DEPTH];

    for (genvar g = 0; g < tsc_pkg::EVENT_DEPTH; g++) begin : g_cell
        tsc_pkg::t_entry w_nb;
        logic            w_we;

        if (g == tsc_pkg::EVENT_DEPTH - 1) begin : g_last
            assign w_nb = '0;
        end else begin : g_mid
            assign w_nb = w_q[g+1];
        end

        assign w_we = i_ctl.we && (i_ctl.widx == tsc_pkg::IDX_W'(g));

        tsc_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_we    (w_we),
            .i_wdata (i_ctl.wdata),
            .i_nb    (w_nb),
            .o_q     (w_q[g])
        );
    end

    assign o_head = w_q[0];

endmodule
